@@ rtl/doh_pkg.sv @@
// Shared types, codes and constants of the DNS-over-HTTPS address extractor.
`default_nettype none
package doh_pkg;

   typedef enum logic [1:0] {
      PH_STATUS = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef enum logic [4:0] {
      S_START         = 5'd0,
      S_FIND_SPACE    = 5'd1,
      S_CODE          = 5'd2,
      S_MAYBE_CONTENT = 5'd3,
      S_IS_CONTENT    = 5'd4,
      S_MAYBE_TYPE    = 5'd5,
      S_MAYBE_LENGTH  = 5'd6,
      S_IS_LENGTH     = 5'd7,
      S_IS_TYPE       = 5'd8,
      S_FIND_EOL      = 5'd9,
      S_QUESTION      = 5'd10,
      S_ANSWER        = 5'd11,
      S_RRTYPE        = 5'd12,
      S_RRCLASS       = 5'd13,
      S_RDLEN         = 5'd14,
      S_RDATA         = 5'd15,
      S_SKIP          = 5'd16,
      S_SKIP_RDLEN    = 5'd17,
      S_EXIT          = 5'd18,
      S_ERROR         = 5'd19
   } sub_state_type;

   localparam logic [1:0] STATUS_BUSY = 2'd0;
   localparam logic [1:0] STATUS_DONE = 2'd1;
   localparam logic [1:0] STATUS_FAIL = 2'd2;

   localparam logic [4:0] CONTENT_LEN = 5'd8;
   localparam logic [4:0] LENGTH_LEN  = 5'd6;
   localparam logic [4:0] TYPE_LEN    = 5'd4;
   localparam logic [4:0] MIME_LEN    = 5'd23;

   localparam logic [15:0] RRTYPE_A    = 16'd1;
   localparam logic [15:0] RRTYPE_AAAA = 16'd28;
   localparam logic [15:0] CLASS_IN    = 16'd1;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      upcase = (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      is_ws = (c == " ") || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= "0") && (c <= "9");
   endfunction

   function automatic logic [7:0] content_char(input logic [4:0] i);
      case (i)
         5'd0: content_char = "C";
         5'd1: content_char = "O";
         5'd2: content_char = "N";
         5'd3: content_char = "T";
         5'd4: content_char = "E";
         5'd5: content_char = "N";
         5'd6: content_char = "T";
         5'd7: content_char = "-";
         default: content_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] length_char(input logic [4:0] i);
      case (i)
         5'd0: length_char = "L";
         5'd1: length_char = "E";
         5'd2: length_char = "N";
         5'd3: length_char = "G";
         5'd4: length_char = "T";
         5'd5: length_char = "H";
         default: length_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] type_char(input logic [4:0] i);
      case (i)
         5'd0: type_char = "T";
         5'd1: type_char = "Y";
         5'd2: type_char = "P";
         5'd3: type_char = "E";
         default: type_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] mime_char(input logic [4:0] i);
      case (i)
         5'd0:  mime_char = "A";
         5'd1:  mime_char = "P";
         5'd2:  mime_char = "P";
         5'd3:  mime_char = "L";
         5'd4:  mime_char = "I";
         5'd5:  mime_char = "C";
         5'd6:  mime_char = "A";
         5'd7:  mime_char = "T";
         5'd8:  mime_char = "I";
         5'd9:  mime_char = "O";
         5'd10: mime_char = "N";
         5'd11: mime_char = "/";
         5'd12: mime_char = "D";
         5'd13: mime_char = "N";
         5'd14: mime_char = "S";
         5'd15: mime_char = "-";
         5'd16: mime_char = "M";
         5'd17: mime_char = "E";
         5'd18: mime_char = "S";
         5'd19: mime_char = "S";
         5'd20: mime_char = "A";
         5'd21: mime_char = "G";
         5'd22: mime_char = "E";
         default: mime_char = 8'h00;
      endcase
   endfunction

endpackage
`default_nettype wire

@@ rtl/doh_response_address_extractor.sv @@
// The result beat of an accepted byte is registered: the edge that accepts the byte loads it.
// Throughput: one byte per cycle; the parser state updates once per byte and
// the result register takes the next beat whenever it is empty or being drained.
// Reset (synchronous, active high) returns the parser to the status line
// phase, clears all counters, selects A records and empties the result register.
// Top level: streams an HTTP DNS response and emits address bytes.
`default_nettype none
module doh_response_address_extractor
   import doh_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_data,        // want_ipv6
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,       // [7:0] data_byte
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,       // [1:0] status, [2] rdata_valid,
                                        // [10:3] rdata_byte, [26:11] record_number,
                                        // [42:27] record_length, [47:43] zero
   output logic        rsp_tlast        // rdata_last
);

   phase_type     phase_ff, phase_in;
   sub_state_type sub_ff, sub_in, ret_ff, ret_in;
   logic [15:0]   code_ff, code_in;
   logic [31:0]   clen_ff, clen_in;
   logic [4:0]    midx_ff, midx_in;
   logic [15:0]   acc_ff, acc_in;
   logic [15:0]   skip_ff, skip_in;
   logic [15:0]   qcnt_ff, qcnt_in;
   logic [15:0]   acnt_ff, acnt_in;
   logic [15:0]   kept_ff, kept_in;
   logic [15:0]   curlen_ff, curlen_in;
   logic          ipv6_ff;

   logic          out_valid_ff;
   logic [42:0]   out_data_ff;
   logic [40:0]   out_data_in;
   logic          out_last_ff, out_last_in;

   logic          take;
   logic [7:0]    c, cu;
   logic [15:0]   v;
   logic [19:0]   code_mul;
   logic [35:0]   clen_mul;
   logic [15:0]   ac_dec;

   // The result register drains or is empty, so a byte can come in.
   assign req_tready = !out_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign c  = req_tdata;
   assign cu = upcase(req_tdata);
   assign v  = {acc_ff[7:0], c};
   assign code_mul = {1'b0, code_ff, 3'b000} + {3'b000, code_ff, 1'b0} + {12'd0, c - 8'd48};
   assign clen_mul = {1'b0, clen_ff, 3'b000} + {3'b000, clen_ff, 1'b0} + {28'd0, c - 8'd48};

   always_comb begin
      phase_in = phase_ff; sub_in = sub_ff; ret_in = ret_ff;
      code_in = code_ff; clen_in = clen_ff; midx_in = midx_ff;
      acc_in = acc_ff; skip_in = skip_ff; qcnt_in = qcnt_ff;
      acnt_in = acnt_ff; kept_in = kept_ff; curlen_in = curlen_ff;
      out_data_in = '0; out_last_in = 1'b0;
      ac_dec = (acnt_ff > 16'd0) ? acnt_ff - 16'd1 : acnt_ff;
      if (sub_ff != S_EXIT && sub_ff != S_ERROR) begin
         case (phase_ff)
            PH_STATUS: begin
               case (sub_ff)
                  S_START: begin
                     if (is_digit(c)) begin
                        sub_in = S_FIND_SPACE; ret_in = S_CODE;
                     end else if (c == 8'h0A) sub_in = S_ERROR;
                  end
                  S_FIND_SPACE: begin
                     if (c == " ") sub_in = ret_ff;
                     else if (c == 8'h0A) sub_in = S_ERROR;
                  end
                  S_CODE: begin
                     if (is_digit(c)) begin
                        code_in = (code_mul > 20'hFFFF) ? 16'hFFFF : code_mul[15:0];
                     end else if (c == 8'h0A) begin
                        if (code_ff < 16'd200 || code_ff > 16'd299) sub_in = S_ERROR;
                        else begin
                           sub_in = S_START; phase_in = PH_HEADER;
                        end
                     end
                  end
                  default: sub_in = S_ERROR;
               endcase
            end
            PH_HEADER: begin
               case (sub_ff)
                  S_START: begin
                     if (cu == "C") begin
                        sub_in = S_MAYBE_CONTENT; midx_in = 5'd1;
                     end else if (c == 8'h0A) begin
                        if (clen_ff > 32'd0 && clen_ff < 32'd12) sub_in = S_ERROR;
                        else begin
                           sub_in = S_START; midx_in = '0; phase_in = PH_BODY;
                        end
                     end else if (!is_ws(c)) begin
                        sub_in = S_FIND_EOL; ret_in = S_START;
                     end
                  end
                  S_MAYBE_CONTENT: begin
                     if (midx_ff < CONTENT_LEN && cu == content_char(midx_ff)) begin
                        midx_in = midx_ff + 5'd1;
                        if (midx_ff + 5'd1 == CONTENT_LEN) sub_in = S_IS_CONTENT;
                     end else begin
                        sub_in = S_FIND_EOL; ret_in = S_START;
                     end
                  end
                  S_IS_CONTENT: begin
                     if (cu == "T") begin
                        sub_in = S_MAYBE_TYPE; midx_in = 5'd1;
                     end else if (cu == "L") begin
                        sub_in = S_MAYBE_LENGTH; midx_in = 5'd1;
                     end else if (c == ":") begin
                        sub_in = S_FIND_EOL; ret_in = S_START;
                     end else if (c == 8'h0A) sub_in = S_START;
                  end
                  S_MAYBE_TYPE: begin
                     if (c == 8'h0A) sub_in = S_START;
                     else if (midx_ff < TYPE_LEN && cu == type_char(midx_ff))
                        midx_in = midx_ff + 5'd1;
                     else if (c == ":") begin
                        if (midx_ff == TYPE_LEN) begin
                           sub_in = S_IS_TYPE; midx_in = '0;
                        end
                     end else begin
                        sub_in = S_FIND_EOL; ret_in = S_START;
                     end
                  end
                  S_MAYBE_LENGTH: begin
                     if (c == 8'h0A) sub_in = S_START;
                     else if (midx_ff < LENGTH_LEN && cu == length_char(midx_ff))
                        midx_in = midx_ff + 5'd1;
                     else if (c == ":") begin
                        if (midx_ff == LENGTH_LEN) sub_in = S_IS_LENGTH;
                     end else if (!is_ws(c)) begin
                        sub_in = S_FIND_EOL; ret_in = S_START;
                     end
                  end
                  S_IS_LENGTH: begin
                     if (is_digit(c))
                        clen_in = (clen_mul > 36'hFFFFFFFF) ? 32'hFFFFFFFF : clen_mul[31:0];
                     else if (c == 8'h0A) sub_in = S_START;
                     else if (!is_ws(c)) sub_in = S_ERROR;
                  end
                  S_IS_TYPE: begin
                     if (c == 8'h0A) sub_in = S_START;
                     else if (!is_ws(c)) begin
                        if (midx_ff < MIME_LEN && cu == mime_char(midx_ff))
                           midx_in = midx_ff + 5'd1;
                        else sub_in = S_ERROR;
                     end
                  end
                  S_FIND_EOL: begin
                     if (c == 8'h0A) sub_in = ret_ff;
                  end
                  default: sub_in = S_ERROR;
               endcase
            end
            PH_BODY: begin
               case (sub_ff)
                  S_START: begin
                     // The counter saturates; only the header bytes look at it.
                     if (midx_ff < 5'd31) midx_in = midx_ff + 5'd1;
                     case (midx_ff)
                        5'd2: if (!c[7]) sub_in = S_ERROR;
                        5'd3: if (c[3:0] != 4'd0) sub_in = S_ERROR;
                        5'd4: qcnt_in = {c, 8'd0};
                        5'd5: qcnt_in = {qcnt_ff[15:8], c};
                        5'd6: acnt_in = {c, 8'd0};
                        5'd7: acnt_in = {acnt_ff[15:8], c};
                        5'd11: begin
                           if (qcnt_ff > 16'd0) sub_in = S_QUESTION;
                           else if (acnt_ff > 16'd0) begin
                              // The name counter restarts and still takes this
                              // byte's step, so a pointer is not seen on the
                              // first answer when there are no questions.
                              sub_in = S_ANSWER; midx_in = 5'd1;
                           end else sub_in = S_EXIT;
                        end
                        default: ;
                     endcase
                  end
                  S_QUESTION: begin
                     if (c == 8'h00) begin
                        qcnt_in = qcnt_ff - 16'd1;
                        // Every question is followed by type and class.
                        skip_in = 16'd4;
                        sub_in  = S_SKIP;
                        if (qcnt_ff - 16'd1 > 16'd0) ret_in = S_QUESTION;
                        else if (acnt_ff > 16'd0) begin
                           ret_in = S_ANSWER; midx_in = '0;
                        end else ret_in = S_EXIT;
                     end
                  end
                  S_ANSWER: begin
                     if (midx_ff == 5'd0 && c[7:6] == 2'b11) begin
                        midx_in = '0; ret_in = S_RRTYPE;
                        skip_in = 16'd1; sub_in = S_SKIP;
                     end else if (c == 8'h00) begin
                        sub_in = S_RRTYPE; midx_in = '0;
                     end else if (midx_ff < 5'd31) midx_in = midx_ff + 5'd1;
                  end
                  S_RRTYPE, S_RRCLASS, S_RDLEN, S_SKIP_RDLEN: begin
                     if (midx_ff == 5'd0) begin
                        acc_in = {8'd0, c}; midx_in = 5'd1;
                     end else begin
                        midx_in = '0;
                        case (sub_ff)
                           S_RRTYPE: begin
                              if (v != (ipv6_ff ? RRTYPE_AAAA : RRTYPE_A)) begin
                                 ret_in = S_SKIP_RDLEN; skip_in = 16'd6; sub_in = S_SKIP;
                              end else sub_in = S_RRCLASS;
                           end
                           S_RRCLASS: begin
                              ret_in  = (v != CLASS_IN) ? S_SKIP_RDLEN : S_RDLEN;
                              skip_in = 16'd4; sub_in = S_SKIP;
                           end
                           S_RDLEN: begin
                              if (v > 16'd0) begin
                                 if (kept_ff != 16'hFFFF) kept_in = kept_ff + 16'd1;
                                 curlen_in = v; acc_in = v; sub_in = S_RDATA;
                              end else begin
                                 acnt_in = ac_dec;
                                 if (qcnt_ff > 16'd0) sub_in = S_QUESTION;
                                 else if (ac_dec > 16'd0) sub_in = S_ANSWER;
                                 else sub_in = S_EXIT;
                              end
                           end
                           default: begin
                              acnt_in = ac_dec;
                              if (qcnt_ff > 16'd0) sub_in = S_QUESTION;
                              else if (ac_dec > 16'd0) sub_in = S_ANSWER;
                              else sub_in = S_EXIT;
                              ret_in = sub_in;
                              if (v != 16'd0) begin
                                 skip_in = v; sub_in = S_SKIP;
                              end
                           end
                        endcase
                     end
                  end
                  S_RDATA: begin
                     out_data_in[0]     = 1'b1;
                     out_data_in[8:1]   = c;
                     out_data_in[24:9]  = kept_ff;
                     out_data_in[40:25] = curlen_ff;
                     if (acc_ff <= 16'd1) begin
                        out_last_in = 1'b1;
                        acnt_in = ac_dec;
                        if (qcnt_ff > 16'd0) sub_in = S_QUESTION;
                        else if (ac_dec > 16'd0) begin
                           sub_in = S_ANSWER; midx_in = '0;
                        end else sub_in = S_EXIT;
                     end else acc_in = acc_ff - 16'd1;
                  end
                  S_SKIP: begin
                     if (skip_ff > 16'd0) skip_in = skip_ff - 16'd1;
                     if (skip_ff <= 16'd1) sub_in = ret_ff;
                  end
                  default: sub_in = S_ERROR;
               endcase
            end
            default: sub_in = S_ERROR;
         endcase
      end
   end

   logic [1:0] st_in;
   assign st_in = (sub_in == S_EXIT) ? STATUS_DONE :
                  (sub_in == S_ERROR) ? STATUS_FAIL : STATUS_BUSY;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STATUS; sub_ff <= S_START; ret_ff <= S_START;
         code_ff <= '0; clen_ff <= '0; midx_ff <= '0; acc_ff <= '0;
         skip_ff <= '0; qcnt_ff <= '0; acnt_ff <= '0; kept_ff <= '0;
         curlen_ff <= '0; ipv6_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) ipv6_ff <= csr_data;
         if (take) begin
            phase_ff <= phase_in; sub_ff <= sub_in; ret_ff <= ret_in;
            code_ff <= code_in; clen_ff <= clen_in; midx_ff <= midx_in;
            acc_ff <= acc_in; skip_ff <= skip_in; qcnt_ff <= qcnt_in;
            acnt_ff <= acnt_in; kept_ff <= kept_in; curlen_ff <= curlen_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_data_ff <= {out_data_in, st_in};
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_data_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

@@ rtl/doh_checker.sv @@
// Port-level checker of the address extractor, bound to the top level.
`default_nettype none
module doh_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [47:0] rsp_tdata,
   input wire        rsp_tlast
);
   a_tlast_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[2]) else $error("tlast without data");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3) else $error("bad status");
   a_beat_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid) else $error("beat lost");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
endmodule

bind doh_response_address_extractor doh_checker u_doh_checker (.*);
`default_nettype wire

@@ bench/doh_extract_checker.sv @@
// Checker for the DNS-over-HTTPS address extractor: predicts and compares every result beat.
`timescale 1ns / 1ps
`default_nettype none
module doh_extract_checker
   import doh_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire         csr_data,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [7:0]  req_tdata,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [47:0] rsp_tdata,
   input  wire         rsp_tlast,
   output int          failures,
   output int          pending,
   output int          address_beats
);

   typedef struct packed {
      logic [1:0]  status;
      logic        addr_valid;
      logic [7:0]  addr_byte;
      logic [15:0] rec_number;
      logic [15:0] rec_length;
      logic        addr_last;
   } parse_result_type;

   localparam logic [183:0] W_CONTENT = "CONTENT-";
   localparam logic [183:0] W_LENGTH  = "LENGTH";
   localparam logic [183:0] W_TYPE    = "TYPE";
   localparam logic [183:0] W_MIME    = "APPLICATION/DNS-MESSAGE";

   parse_result_type expected_beats[$];

   logic          want_ipv6;
   phase_type     phase;
   sub_state_type sub_state, return_state;
   logic [15:0]   status_code;
   logic [31:0]   content_length;
   logic [4:0]    match_index;
   logic [15:0]   field_acc, skip_count, question_count, answer_count;
   logic [15:0]   kept_records, current_length;

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic logic blank(input logic [7:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Word characters sit right-aligned, so character i is 8*(len-1-i) bits up.
   function automatic logic word_hit(input logic [183:0] w, input int len,
                                     input logic [4:0] idx, input logic [7:0] c);
      if (idx >= len) return 1'b0;
      return fold(c) == w[8 * (len - 1 - idx) +: 8];
   endfunction

   function automatic void next_record();
      if (question_count > 0) sub_state = S_QUESTION;
      else if (answer_count > 0) begin
         sub_state = S_ANSWER;
         match_index = 0;
      end else sub_state = S_EXIT;
   endfunction

   function automatic void answer_done();
      if (answer_count > 0) answer_count--;
      next_record();
   endfunction

   function automatic void start_skip(input logic [15:0] n);
      return_state = sub_state;
      if (n != 0) begin
         skip_count = n;
         sub_state = S_SKIP;
      end
   endfunction

   function automatic void parse_status(input logic [7:0] c);
      logic [31:0] v;
      case (sub_state)
         S_START:
            if (digit(c)) begin
               sub_state = S_FIND_SPACE;
               return_state = S_CODE;
            end else if (c == "\n") sub_state = S_ERROR;
         S_FIND_SPACE:
            if (c == " ") sub_state = return_state;
            else if (c == "\n") sub_state = S_ERROR;
         S_CODE:
            if (digit(c)) begin
               v = status_code * 32'd10 + (c - "0");
               status_code = v > 32'hFFFF ? 16'hFFFF : v[15:0];
            end else if (c == "\n") begin
               if (status_code / 100 != 2) sub_state = S_ERROR;
               else begin
                  sub_state = S_START;
                  phase = PH_HEADER;
               end
            end
         default: sub_state = S_ERROR;
      endcase
   endfunction

   function automatic void parse_header(input logic [7:0] c);
      logic [63:0] v;
      case (sub_state)
         S_START:
            if (fold(c) == "C") begin
               sub_state = S_MAYBE_CONTENT;
               match_index = 1;
            end else if (c == "\n") begin
               if (content_length > 0 && content_length < 12) sub_state = S_ERROR;
               else begin
                  sub_state = S_START;
                  match_index = 0;
                  phase = PH_BODY;
               end
            end else if (!blank(c)) begin
               sub_state = S_FIND_EOL;
               return_state = S_START;
            end
         S_MAYBE_CONTENT:
            if (word_hit(W_CONTENT, 8, match_index, c)) begin
               match_index++;
               if (match_index == 8) sub_state = S_IS_CONTENT;
            end else begin
               sub_state = S_FIND_EOL;
               return_state = S_START;
            end
         S_IS_CONTENT:
            if (fold(c) == "T") begin
               sub_state = S_MAYBE_TYPE;
               match_index = 1;
            end else if (fold(c) == "L") begin
               sub_state = S_MAYBE_LENGTH;
               match_index = 1;
            end else if (c == ":") begin
               sub_state = S_FIND_EOL;
               return_state = S_START;
            end else if (c == "\n") sub_state = S_START;
         S_MAYBE_TYPE:
            if (c == "\n") sub_state = S_START;
            else if (word_hit(W_TYPE, 4, match_index, c)) match_index++;
            else if (c == ":") begin
               if (match_index == 4) begin
                  sub_state = S_IS_TYPE;
                  match_index = 0;
               end
            end else begin
               sub_state = S_FIND_EOL;
               return_state = S_START;
            end
         S_MAYBE_LENGTH:
            if (c == "\n") sub_state = S_START;
            else if (word_hit(W_LENGTH, 6, match_index, c)) match_index++;
            else if (c == ":") begin
               if (match_index == 6) sub_state = S_IS_LENGTH;
            end else if (!blank(c)) begin
               sub_state = S_FIND_EOL;
               return_state = S_START;
            end
         S_IS_LENGTH:
            if (digit(c)) begin
               v = content_length * 64'd10 + (c - "0");
               content_length = v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
            end else if (c == "\n") sub_state = S_START;
            else if (!blank(c)) sub_state = S_ERROR;
         S_IS_TYPE:
            if (c == "\n") sub_state = S_START;
            else if (!blank(c)) begin
               if (word_hit(W_MIME, 23, match_index, c)) match_index++;
               else sub_state = S_ERROR;
            end
         S_FIND_EOL:
            if (c == "\n") sub_state = return_state;
         default: sub_state = S_ERROR;
      endcase
   endfunction

   function automatic void parse_body(input logic [7:0] c, inout parse_result_type r);
      logic [15:0] v;
      case (sub_state)
         S_START: begin
            case (match_index)
               5'd2: if (!c[7]) sub_state = S_ERROR;
               5'd3: if (c[3:0] != 0) sub_state = S_ERROR;
               5'd4: question_count = {c, 8'h00};
               5'd5: question_count = question_count | c;
               5'd6: answer_count = {c, 8'h00};
               5'd7: answer_count = answer_count | c;
               5'd11: next_record();
               default: ;
            endcase
            if (match_index < 31) match_index++;
         end
         S_QUESTION:
            if (c == 0) begin
               question_count--;
               next_record();
               start_skip(4);
            end
         S_ANSWER: begin
            if (match_index < 31) match_index++;
            if (match_index == 1 && c[7:6] == 2'b11) begin
               match_index = 0;
               sub_state = S_RRTYPE;
               start_skip(1);
            end else if (c == 0) begin
               sub_state = S_RRTYPE;
               match_index = 0;
            end
         end
         S_RRTYPE, S_RRCLASS, S_RDLEN, S_SKIP_RDLEN:
            if (match_index == 0) begin
               field_acc = {8'h00, c};
               match_index = 1;
            end else begin
               v = {field_acc[7:0], c};
               match_index = 0;
               if (sub_state == S_RRTYPE) begin
                  if (v != (want_ipv6 ? 16'd28 : 16'd1)) begin
                     sub_state = S_SKIP_RDLEN;
                     start_skip(6);
                  end else sub_state = S_RRCLASS;
               end else if (sub_state == S_RRCLASS) begin
                  sub_state = (v != 1) ? S_SKIP_RDLEN : S_RDLEN;
                  start_skip(4);
               end else if (sub_state == S_RDLEN) begin
                  if (v > 0) begin
                     if (kept_records < 16'hFFFF) kept_records++;
                     current_length = v;
                     field_acc = v;
                     sub_state = S_RDATA;
                  end else answer_done();
               end else begin
                  answer_done();
                  start_skip(v);
               end
            end
         S_RDATA: begin
            r.addr_valid = 1'b1;
            r.addr_byte = c;
            r.rec_number = kept_records;
            r.rec_length = current_length;
            if (field_acc <= 1) begin
               r.addr_last = 1'b1;
               answer_done();
            end else field_acc--;
         end
         S_SKIP: begin
            if (skip_count > 0) skip_count--;
            if (skip_count == 0) sub_state = return_state;
         end
         default: sub_state = S_ERROR;
      endcase
   endfunction

   function automatic parse_result_type parse_byte(input logic [7:0] c);
      parse_result_type r;
      r = '0;
      if (sub_state != S_EXIT && sub_state != S_ERROR) begin
         case (phase)
            PH_STATUS: parse_status(c);
            PH_HEADER: parse_header(c);
            PH_BODY:   parse_body(c, r);
            default:   sub_state = S_ERROR;
         endcase
      end
      r.status = (sub_state == S_EXIT) ? STATUS_DONE :
                 (sub_state == S_ERROR) ? STATUS_FAIL : STATUS_BUSY;
      return r;
   endfunction

   task automatic compare(input string name, input logic [15:0] exp, input logic [15:0] act);
      if (exp !== act) begin
         $error("%s: expected %0h, got %0h", name, exp, act);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      parse_result_type e;
      if (reset) begin
         expected_beats.delete();
         want_ipv6 = 0;
         phase = PH_STATUS;
         sub_state = S_START;
         return_state = S_START;
         status_code = 0;
         content_length = 0;
         match_index = 0;
         field_acc = 0;
         skip_count = 0;
         question_count = 0;
         answer_count = 0;
         kept_records = 0;
         current_length = 0;
         failures = 0;
         address_beats = 0;
      end else begin
         if (csr_valid && csr_ready) want_ipv6 = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_beats.size() == 0) begin
               $error("result beat with nothing expected: %h", rsp_tdata);
               failures++;
            end else begin
               e = expected_beats.pop_front();
               compare("status", 16'(e.status), 16'(rsp_tdata[1:0]));
               compare("rdata_valid", 16'(e.addr_valid), 16'(rsp_tdata[2]));
               compare("rdata_byte", 16'(e.addr_byte), 16'(rsp_tdata[10:3]));
               compare("record_number", e.rec_number, rsp_tdata[26:11]);
               compare("record_length", e.rec_length, rsp_tdata[42:27]);
               compare("padding", 16'h0, 16'(rsp_tdata[47:43]));
               compare("rdata_last", 16'(e.addr_last), 16'(rsp_tlast));
               if (e.addr_valid) address_beats++;
            end
         end
         if (req_tvalid && req_tready) expected_beats.push_back(parse_byte(req_tdata));
      end
      pending = expected_beats.size();
   end

endmodule
`default_nettype wire

@@ bench/tb_doh_response_address_extractor.sv @@
// Testbench top: builds a long DoH response, drives it with random gaps and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_doh_response_address_extractor
   import doh_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;

   int failures, pending, address_beats;

   // When set, both sides stop idling, so back-to-back beats are exercised too.
   bit steady = 1'b0;
   int rsp_wait = 0;

   // The whole response as a list of bytes, and the byte positions before which
   // the address family is switched, together with the new setting.
   logic [7:0] response_bytes[$];
   int         switch_at[$];
   bit         switch_to[$];
   int         answer_total;

   doh_response_address_extractor dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   doh_extract_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .failures(failures), .pending(pending), .address_beats(address_beats)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Safety net: the slowest correct run is well under half a millisecond.
   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, 10);
   endfunction

   // Result side: after each accepted beat a fresh stall length is drawn, so the
   // stalls land on every state of the parser.
   always @(posedge clock) begin
      int w;
      if (reset) rsp_tready <= 1'b0;
      else if (rsp_tvalid && rsp_tready) begin
         w = draw_gap();
         rsp_wait = w;
         rsp_tready <= (w == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= (rsp_wait == 0);
      end else rsp_tready <= 1'b1;
   end

   // Appends text, folding letters to a random case when asked.
   task automatic add_text(input string s, input bit mix_case);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mix_case && c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c + 8'd32;
         response_bytes.push_back(c);
      end
   endtask

   task automatic add_random(input int n, inout logic [7:0] q[$]);
      for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
   endtask

   // A plain name of one to three labels; label lengths never look like a pointer.
   task automatic add_name(inout logic [7:0] q[$]);
      int labels, n;
      labels = $urandom_range(1, 3);
      for (int l = 0; l < labels; l++) begin
         n = $urandom_range(1, 5);
         q.push_back(8'(n));
         for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(1, 255)));
      end
      q.push_back(8'h00);
   endtask

   task automatic add_word(input logic [15:0] v, inout logic [7:0] q[$]);
      q.push_back(v[15:8]);
      q.push_back(v[7:0]);
   endtask

   // Builds the status line, the header block and a DNS message whose answers
   // mix kept and skipped records, both name forms and odd lengths.
   task automatic build_response();
      logic [7:0]  answers[$];
      logic [7:0]  dns[$];
      logic [15:0] rtype, rclass, rdlen;
      int          questions, pick, body_start;
      bit          family;
      family = 1'b0;
      answer_total = 0;
      add_text($sformatf("HTTP/1.1 %0d OK\r\n", $urandom_range(200, 299)), 1'b0);
      // Header cases: mixed case names, a repeated length that saturates, a name
      // running past its word, a type with padding and a prefix type.
      add_text("Host: resolver.example\r\n", 1'b1);
      add_text("Content-Length: 0\r\n", 1'b1);
      add_text("CONTENT-LENGTH:  99999999999999\r\n", 1'b1);
      add_text("Content-Lengthy: 3\r\n", 1'b1);
      add_text("Content-Typed: text/html\r\n", 1'b1);
      add_text("Content-Encoding: none\r\n", 1'b1);
      add_text("Content-Type: \tApplication/DNS-Message  \r\n", 1'b1);
      add_text("content-type: application/dns\r\n", 1'b1);
      add_text("X-Pad:\r\n\r\n", 1'b1);
      body_start = response_bytes.size();

      questions = $urandom_range(1, 2);
      while (answers.size() < 1450) begin
         // Change the wanted family every few dozen answers, at an answer boundary.
         // The position is kept as an offset into the answer section for now.
         if (answer_total % 40 == 39) begin
            family = !family;
            switch_at.push_back(answers.size());
            switch_to.push_back(family);
         end
         if ($urandom_range(0, 1)) begin
            answers.push_back(8'(8'hC0 | $urandom_range(0, 63)));
            answers.push_back(8'($urandom_range(0, 255)));
         end else add_name(answers);
         pick = $urandom_range(0, 9);
         rtype = pick < 6 ? (family ? RRTYPE_AAAA : RRTYPE_A) :
                 pick < 8 ? (family ? RRTYPE_A : RRTYPE_AAAA) :
                 16'($urandom_range(0, 65535));
         rclass = $urandom_range(0, 7) != 0 ? CLASS_IN : 16'($urandom_range(0, 65535));
         pick = $urandom_range(0, 9);
         rdlen = pick < 7 ? (rtype == RRTYPE_AAAA ? 16'd16 : 16'd4) :
                 pick == 7 ? 16'd0 : 16'($urandom_range(1, 12));
         add_word(rtype, answers);
         add_word(rclass, answers);
         add_random(4, answers);
         add_word(rdlen, answers);
         add_random(rdlen, answers);
         answer_total++;
      end

      // DNS header: QR set, RCODE zero, the counts, then the remaining fields.
      add_random(2, dns);
      dns.push_back(8'(8'h80 | $urandom_range(0, 127)));
      dns.push_back({4'($urandom_range(0, 15)), 4'h0});
      add_word(16'(questions), dns);
      add_word(16'(answer_total), dns);
      add_random(4, dns);
      for (int k = 0; k < questions; k++) begin
         add_name(dns);
         add_random(4, dns);
      end
      foreach (dns[i]) response_bytes.push_back(dns[i]);
      foreach (answers[i]) response_bytes.push_back(answers[i]);
      // Turn the switch offsets into positions in the whole response.
      foreach (switch_at[k]) switch_at[k] = switch_at[k] + body_start + dns.size();
      // A few trailing bytes that the finished parser must ignore.
      add_random(6, response_bytes);
   endtask

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   // Waits until every expected beat has come back; the count is read at the
   // falling edge, after the checker has settled.
   task automatic drain();
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Configuration is only written once every expected beat has come back.
   task automatic write_family(input bit v);
      req_tvalid <= 1'b0;
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int next_switch, i;
      logic [7:0] b;
      build_response();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_family(1'b1);
      write_family(1'b0);

      // The stream is sent byte by byte; just before an answer that starts a new
      // family block the input pauses, the backlog drains and the family is set.
      next_switch = 0;
      i = 0;
      while (i < response_bytes.size()) begin
         if (next_switch < switch_at.size() && i == switch_at[next_switch]) begin
            write_family(switch_to[next_switch]);
            next_switch++;
         end
         b = response_bytes[i];
         if (i % 150 == 0) steady = ($urandom_range(0, 3) == 0);
         send_byte(b);
         i++;
      end
      req_tvalid <= 1'b0;
      drain();
      repeat (5) @(posedge clock);

      $display("Sent %0d response bytes holding %0d answers over %0d family switches.",
               response_bytes.size(), answer_total, next_switch);
      $display("%0d address beats were checked along the way.", address_beats);
      if (failures == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/doh_pkg.sv
rtl/doh_response_address_extractor.sv
rtl/doh_checker.sv
bench/doh_extract_checker.sv
bench/tb_doh_response_address_extractor.sv
